>>> rtl/core/byte_ring_buffer_burst_defines.svh
// Assertion macros shared by the byte ring buffer RTL.
// Needs i_clk and i_rst_n in the scope where a macro is used.
`ifndef BYTE_RING_BUFFER_BURST_DEFINES_SVH
`define BYTE_RING_BUFFER_BURST_DEFINES_SVH
`ifndef SYNTH
`define BRB_ASSERT_IMP(lbl, ante, cons, msg) \
    lbl: assert property (@(posedge i_clk) disable iff (!i_rst_n) (ante) |-> (cons)) \
        else $error(msg);
`define BRB_ASSERT_ALW(lbl, cond, msg) \
    lbl: assert property (@(posedge i_clk) disable iff (!i_rst_n) (cond)) \
        else $error(msg);
`else
`define BRB_ASSERT_IMP(lbl, ante, cons, msg)
`define BRB_ASSERT_ALW(lbl, cond, msg)
`endif
`endif

>>> rtl/core/brb_pkg.sv
// Types and codes for the byte ring buffer.
// No dependencies.
package brb_pkg;

    localparam int CNT_W  = 4;
    localparam int POS_W  = 32;
    localparam int DATA_W = 64;

    localparam logic [1:0] OP_ADD    = 2'd0;
    localparam logic [1:0] OP_REMOVE = 2'd1;
    localparam logic [1:0] OP_PEEK   = 2'd2;

    typedef enum logic [1:0] {
        KIND_EMPTY = 2'd0,
        KIND_WRITE = 2'd1,
        KIND_READ  = 2'd2
    } t_kind;

    // Job handed from the front end to the back end (slot travels beside it).
    typedef struct packed {
        t_kind              kind;
        logic [CNT_W-1:0]   gnt;
        logic [POS_W-1:0]   pos;
        logic [DATA_W-1:0]  data;
    } t_job;

endpackage

>>> rtl/core/brb_ram.sv
// Generic single-port RAM with registered read.
// No dependencies.
module brb_ram #(
    parameter int WIDTH = 8,
    parameter int DEPTH = 1024
) (
    input  logic                     i_clk,
    input  logic                     i_we,
    input  logic                     i_re,
    input  logic [$clog2(DEPTH)-1:0] i_addr,
    input  logic [WIDTH-1:0]         i_wdata,
    output logic [WIDTH-1:0]         o_rdata
);

    logic [WIDTH-1:0] r_mem [DEPTH];
    logic [WIDTH-1:0] r_rdata;

    always_ff @(posedge i_clk) begin
        if (i_we) begin
            r_mem[i_addr] <= i_wdata;
        end
        if (i_re) begin
            r_rdata <= r_mem[i_addr];
        end
    end

    assign o_rdata = r_rdata;

endmodule

>>> rtl/core/brb_queue.sv
// Two-entry job queue between front and back end.
// No dependencies.
module brb_queue #(
    parameter int WIDTH = 8
) (
    input  logic             i_clk,
    input  logic             i_rst_n,
    input  logic             i_push,
    input  logic [WIDTH-1:0] i_wdata,
    input  logic             i_pop,
    output logic [WIDTH-1:0] o_rdata,
    output logic             o_full,
    output logic             o_empty
);

    logic [WIDTH-1:0] r_mem [2];
    logic             r_wp, r_rp;
    logic [1:0]       r_cnt;
    logic [1:0]       n_cnt;

    assign n_cnt   = r_cnt + 2'(i_push) - 2'(i_pop);
    assign o_full  = (r_cnt == 2'd2);
    assign o_empty = (r_cnt == 2'd0);
    assign o_rdata = r_mem[r_rp];

    always_ff @(posedge i_clk) begin
        if (i_push) begin
            r_mem[r_wp] <= i_wdata;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wp  <= 1'b0;
            r_rp  <= 1'b0;
            r_cnt <= 2'd0;
        end else begin
            if (i_push) begin
                r_wp <= ~r_wp;
            end
            if (i_pop) begin
                r_rp <= ~r_rp;
            end
            r_cnt <= n_cnt;
        end
    end

endmodule

>>> rtl/core/brb_front.sv
// Front end: input stage, occupancy bookkeeping and request classification.
// Depends on brb_pkg and byte_ring_buffer_burst_defines.svh.
`include "byte_ring_buffer_burst_defines.svh"
module brb_front #(
    parameter int DEPTH     = 1024,
    parameter int MAX_BURST = 8
) (
    input  logic                        i_clk,
    input  logic                        i_rst_n,
    input  logic                        i_valid,
    output logic                        o_ready,
    input  logic [1:0]                  i_operation,
    input  logic [brb_pkg::CNT_W-1:0]   i_count,
    input  logic [brb_pkg::DATA_W-1:0]  i_add_bytes,
    input  logic                        i_from_head,
    input  logic [brb_pkg::POS_W-1:0]   i_position,
    output logic                        o_push,
    input  logic                        i_full,
    output brb_pkg::t_job               o_job,
    output logic [$clog2(DEPTH)-1:0]    o_slot
);

    localparam int SW = $clog2(DEPTH);
    localparam int TW = SW + 6;
    localparam longint unsigned KMOD = (64'd1 << 32) % DEPTH;
    // slot jump when a position wraps past 2^32
    localparam logic [TW-1:0] KW = TW'(KMOD);
    localparam logic [TW-1:0] DW = TW'(DEPTH);

    logic                        r_vld;
    logic [1:0]                  r_op;
    logic [brb_pkg::CNT_W-1:0]   r_cnt;
    logic [brb_pkg::DATA_W-1:0]  r_bytes;
    logic                        r_head;
    logic [brb_pkg::POS_W-1:0]   r_posn;

    logic [31:0]   r_rd, r_wr, n_rd, n_wr;
    logic [SW-1:0] r_rd_slot, r_wr_slot, n_rd_slot, n_wr_slot;

    logic [31:0]   occ, free_b, pk_start, pk_off, pk_avail;
    logic [32:0]   pk_sum;
    logic [3:0]    cnt_c, rm_n, pk_n;
    logic          add_ok, pk_in;
    logic [SW-1:0] pk_slot;

    function automatic logic [SW-1:0] wrap_slot(input logic [TW-1:0] t);
        logic [TW-1:0] r;
        r = t;
        if (t[TW-1]) begin
            r = t + DW;
        end else if (t >= DW) begin
            r = t - DW;
        end
        return r[SW-1:0];
    endfunction

    function automatic logic [SW-1:0] adv_slot(input logic [SW-1:0] slot,
                                               input logic [31:0] pos,
                                               input logic [3:0] n);
        logic [32:0]   s;
        logic [TW-1:0] t;
        s = {1'b0, pos} + 33'(n);
        t = TW'(slot) + TW'(n) - (s[32] ? KW : '0);
        return wrap_slot(t);
    endfunction

    assign o_push  = r_vld && !i_full;
    assign o_ready = !r_vld || o_push;

    always_comb begin
        occ      = r_wr - r_rd;
        free_b   = 32'(DEPTH) - occ;
        cnt_c    = (r_cnt > 4'(MAX_BURST)) ? 4'(MAX_BURST) : r_cnt;
        add_ok   = (r_cnt != 4'd0) && (r_cnt <= 4'(MAX_BURST)) && (32'(r_cnt) <= free_b);
        rm_n     = (32'(cnt_c) > occ) ? occ[3:0] : cnt_c;
        pk_start = r_head ? r_rd : r_posn;
        pk_off   = pk_start - r_rd;
        pk_in    = (pk_off < occ);
        pk_avail = occ - pk_off;
        pk_n     = (32'(cnt_c) > pk_avail) ? pk_avail[3:0] : cnt_c;
        pk_sum   = {1'b0, r_rd} + {1'b0, pk_off};
        pk_slot  = wrap_slot(TW'(r_rd_slot) + TW'(pk_off[SW-1:0]) - (pk_sum[32] ? KW : '0));
    end

    always_comb begin
        o_job      = '0;
        o_job.kind = brb_pkg::KIND_EMPTY;
        o_slot     = r_rd_slot;
        n_rd       = r_rd;
        n_wr       = r_wr;
        n_rd_slot  = r_rd_slot;
        n_wr_slot  = r_wr_slot;
        case (r_op)
            brb_pkg::OP_ADD: begin
                if (add_ok) begin
                    o_job.kind = brb_pkg::KIND_WRITE;
                    o_job.gnt  = r_cnt;
                    o_job.pos  = r_wr;
                    o_job.data = r_bytes;
                    o_slot     = r_wr_slot;
                    n_wr       = r_wr + 32'(r_cnt);
                    n_wr_slot  = adv_slot(r_wr_slot, r_wr, r_cnt);
                end
            end
            brb_pkg::OP_REMOVE: begin
                if (rm_n != 4'd0) begin
                    o_job.kind = brb_pkg::KIND_READ;
                    o_job.gnt  = rm_n;
                    o_job.pos  = r_rd;
                    o_slot     = r_rd_slot;
                    n_rd       = r_rd + 32'(rm_n);
                    n_rd_slot  = adv_slot(r_rd_slot, r_rd, rm_n);
                end
            end
            brb_pkg::OP_PEEK: begin
                if (pk_in && (pk_n != 4'd0)) begin
                    o_job.kind = brb_pkg::KIND_READ;
                    o_job.gnt  = pk_n;
                    o_job.pos  = pk_start;
                    o_slot     = pk_slot;
                end
            end
            default: begin
                o_job.kind = brb_pkg::KIND_EMPTY;
            end
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (i_valid && o_ready) begin
            r_op    <= i_operation;
            r_cnt   <= i_count;
            r_bytes <= i_add_bytes;
            r_head  <= i_from_head;
            r_posn  <= i_position;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_vld     <= 1'b0;
            r_rd      <= 32'd1;
            r_wr      <= 32'd1;
            r_rd_slot <= SW'(1);
            r_wr_slot <= SW'(1);
        end else begin
            if (o_ready) begin
                r_vld <= i_valid;
            end
            if (o_push) begin
                r_rd      <= n_rd;
                r_wr      <= n_wr;
                r_rd_slot <= n_rd_slot;
                r_wr_slot <= n_wr_slot;
            end
        end
    end

    `BRB_ASSERT_ALW(a_occ_bound, (r_wr - r_rd) <= 32'(DEPTH), "occupancy above depth")
    `BRB_ASSERT_ALW(a_slot_range, ((SW+1)'(r_rd_slot) < (SW+1)'(DEPTH)) && ((SW+1)'(r_wr_slot) < (SW+1)'(DEPTH)), "slot out of range")
    `BRB_ASSERT_IMP(a_read_in_window, o_push && (o_job.kind == brb_pkg::KIND_READ), 32'(o_job.gnt) <= occ, "read grant above occupancy")

endmodule

>>> rtl/core/brb_back.sv
// Back end: walks a job through the byte RAM one byte a cycle (reads stall while the output is held), drives results.
// Depends on brb_pkg, brb_ram and byte_ring_buffer_burst_defines.svh.
`include "byte_ring_buffer_burst_defines.svh"
module brb_back #(
    parameter int DEPTH = 1024
) (
    input  logic                        i_clk,
    input  logic                        i_rst_n,
    input  logic                        i_empty,
    input  brb_pkg::t_job               i_job,
    input  logic [$clog2(DEPTH)-1:0]    i_slot,
    output logic                        o_pop,
    output logic                        o_valid,
    input  logic                        i_ready,
    output logic [brb_pkg::CNT_W-1:0]   o_granted,
    output logic [7:0]                  o_data_byte,
    output logic                        o_has_data,
    output logic                        o_last
);

    localparam int SW = $clog2(DEPTH);

    typedef enum logic [3:0] {
        S_IDLE  = 4'b0001,
        S_WRITE = 4'b0010,
        S_READ  = 4'b0100,
        S_DONE  = 4'b1000
    } t_bstate;

    t_bstate r_state, n_state;

    logic [3:0]                  r_gnt, r_rem, n_rem;
    logic [SW-1:0]               r_slot, n_slot, nxt_slot;
    logic [31:0]                 r_pos, n_pos;
    logic [brb_pkg::DATA_W-1:0]  r_data, n_data;

    logic       r_pend, r_pend_last;
    logic [3:0] r_pend_gnt;

    logic       r_out_vld, r_out_has, r_out_last;
    logic [3:0] r_out_gnt;
    logic [7:0] r_out_byte;

    logic       out_free, pend_drain, issue, done_load, ram_we;
    logic [7:0] ram_rdata;

    assign out_free   = !r_out_vld || i_ready;
    assign pend_drain = r_pend && out_free;
    assign issue      = (r_state == S_READ) && (!r_pend || pend_drain);
    assign done_load  = (r_state == S_DONE) && !r_pend && out_free;
    assign ram_we     = (r_state == S_WRITE);
    assign o_pop      = (r_state == S_IDLE) && !i_empty;
    // position wrap past 2^32 lands on slot 0, same as the end of the ring
    assign nxt_slot   = ((r_pos == 32'hFFFF_FFFF) || (r_slot == SW'(DEPTH - 1))) ?
                        '0 : r_slot + 1'b1;

    brb_ram #(
        .WIDTH (8),
        .DEPTH (DEPTH)
    ) u_ram (
        .i_clk   (i_clk),
        .i_we    (ram_we),
        .i_re    (issue),
        .i_addr  (r_slot),
        .i_wdata (r_data[7:0]),
        .o_rdata (ram_rdata)
    );

    always_comb begin
        n_state = r_state;
        n_rem   = r_rem;
        n_slot  = r_slot;
        n_pos   = r_pos;
        n_data  = r_data;
        case (r_state)
            S_IDLE: begin
                if (!i_empty) begin
                    n_rem  = i_job.gnt;
                    n_slot = i_slot;
                    n_pos  = i_job.pos;
                    n_data = i_job.data;
                    case (i_job.kind)
                        brb_pkg::KIND_WRITE: n_state = S_WRITE;
                        brb_pkg::KIND_READ:  n_state = S_READ;
                        default:             n_state = S_DONE;
                    endcase
                end
            end
            S_WRITE: begin
                n_rem  = r_rem - 4'd1;
                n_slot = nxt_slot;
                n_pos  = r_pos + 32'd1;
                n_data = r_data >> 8;
                if (r_rem == 4'd1) begin
                    n_state = S_DONE;
                end
            end
            S_READ: begin
                if (issue) begin
                    n_rem  = r_rem - 4'd1;
                    n_slot = nxt_slot;
                    n_pos  = r_pos + 32'd1;
                    if (r_rem == 4'd1) begin
                        n_state = S_IDLE;
                    end
                end
            end
            S_DONE: begin
                if (done_load) begin
                    n_state = S_IDLE;
                end
            end
            default: n_state = S_IDLE;
        endcase
    end

    always_ff @(posedge i_clk) begin
        r_rem  <= n_rem;
        r_slot <= n_slot;
        r_pos  <= n_pos;
        r_data <= n_data;
        if (o_pop) begin
            r_gnt <= i_job.gnt;
        end
        if (issue) begin
            r_pend_gnt  <= r_gnt;
            r_pend_last <= (r_rem == 4'd1);
        end
        if (pend_drain) begin
            r_out_gnt  <= r_pend_gnt;
            r_out_byte <= ram_rdata;
            r_out_has  <= 1'b1;
            r_out_last <= r_pend_last;
        end else if (done_load) begin
            r_out_gnt  <= r_gnt;
            r_out_byte <= 8'd0;
            r_out_has  <= 1'b0;
            r_out_last <= 1'b1;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state   <= S_IDLE;
            r_pend    <= 1'b0;
            r_out_vld <= 1'b0;
        end else begin
            r_state <= n_state;
            if (issue) begin
                r_pend <= 1'b1;
            end else if (pend_drain) begin
                r_pend <= 1'b0;
            end
            if (pend_drain || done_load) begin
                r_out_vld <= 1'b1;
            end else if (i_ready) begin
                r_out_vld <= 1'b0;
            end
        end
    end

    assign o_valid     = r_out_vld;
    assign o_granted   = r_out_gnt;
    assign o_data_byte = r_out_byte;
    assign o_has_data  = r_out_has;
    assign o_last      = r_out_last;

    `BRB_ASSERT_IMP(a_rem_nz, (r_state == S_WRITE) || (r_state == S_READ), r_rem != 4'd0, "byte walk with nothing left")
    `BRB_ASSERT_IMP(a_has_gnt, r_out_vld && r_out_has, r_out_gnt != 4'd0, "data word with zero grant")
    `BRB_ASSERT_IMP(a_no_pop_busy, o_pop, !r_pend || (r_state == S_IDLE), "job taken outside idle")

endmodule

>>> rtl/core/byte_ring_buffer_burst.sv
// A request passes the input stage and the two-entry job queue before the back end
// walks it. Throughput: one byte per cycle through the single-port byte RAM while
// the output is not held; the back end takes the next job only once back in idle.
// Reset (synchronous, active low): read and write positions go to 1, queue and
// output register empty; RAM contents are not cleared.
module byte_ring_buffer_burst #(
    parameter int DEPTH     = 1024,
    parameter int MAX_BURST = 8
) (
    input  logic                        i_clk,
    input  logic                        i_rst_n,
    input  logic                        i_valid,
    output logic                        o_ready,
    input  logic [1:0]                  i_operation,
    input  logic [brb_pkg::CNT_W-1:0]   i_count,
    input  logic [brb_pkg::DATA_W-1:0]  i_add_bytes,
    input  logic                        i_from_head,
    input  logic [brb_pkg::POS_W-1:0]   i_position,
    output logic                        o_valid,
    input  logic                        i_ready,
    output logic [brb_pkg::CNT_W-1:0]   o_granted,
    output logic [7:0]                  o_data_byte,
    output logic                        o_has_data,
    output logic                        o_last
);

    localparam int SW = $clog2(DEPTH);
    localparam int QW = $bits(brb_pkg::t_job) + SW;

    logic          push, q_full, q_empty, pop;
    brb_pkg::t_job f_job, b_job;
    logic [SW-1:0] f_slot, b_slot;
    logic [QW-1:0] q_rdata;

    brb_front #(
        .DEPTH     (DEPTH),
        .MAX_BURST (MAX_BURST)
    ) u_front (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_valid     (i_valid),
        .o_ready     (o_ready),
        .i_operation (i_operation),
        .i_count     (i_count),
        .i_add_bytes (i_add_bytes),
        .i_from_head (i_from_head),
        .i_position  (i_position),
        .o_push      (push),
        .i_full      (q_full),
        .o_job       (f_job),
        .o_slot      (f_slot)
    );

    brb_queue #(
        .WIDTH (QW)
    ) u_queue (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_push  (push),
        .i_wdata ({f_job, f_slot}),
        .i_pop   (pop),
        .o_rdata (q_rdata),
        .o_full  (q_full),
        .o_empty (q_empty)
    );

    assign b_job  = q_rdata[QW-1:SW];
    assign b_slot = q_rdata[SW-1:0];

    brb_back #(
        .DEPTH (DEPTH)
    ) u_back (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_empty     (q_empty),
        .i_job       (b_job),
        .i_slot      (b_slot),
        .o_pop       (pop),
        .o_valid     (o_valid),
        .i_ready     (i_ready),
        .o_granted   (o_granted),
        .o_data_byte (o_data_byte),
        .o_has_data  (o_has_data),
        .o_last      (o_last)
    );

endmodule
